[hdl/modbus_rtu_master_framer_assert.svh]
// concurrent assertion helpers for the modbus rtu master framer
`ifndef MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH
`define MODBUS_RTU_MASTER_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MBF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBF_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define MBF_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

[hdl/mbf_pkg.sv]
`default_nettype none

package mbf_pkg;

    localparam int BUF_DEPTH_DEF = 256;
    localparam int PDU_SIZE_MIN  = 4;

    localparam logic [7:0] MAX_ADDR_RST = 8'd247;

    // command codes
    localparam logic [2:0] CMD_RX_BYTE  = 3'd0;
    localparam logic [2:0] CMD_TX_READY = 3'd1;
    localparam logic [2:0] CMD_TIMER    = 3'd2;
    localparam logic [2:0] CMD_ADDRESS  = 3'd3;
    localparam logic [2:0] CMD_PDU_BYTE = 3'd4;
    localparam logic [2:0] CMD_SEND     = 3'd5;
    localparam logic [2:0] CMD_READ     = 3'd6;

    // result kinds
    localparam logic [3:0] KIND_ACK      = 4'd0;
    localparam logic [3:0] KIND_TX_BYTE  = 4'd1;
    localparam logic [3:0] KIND_TX_DONE  = 4'd2;
    localparam logic [3:0] KIND_READY    = 4'd3;
    localparam logic [3:0] KIND_FRAME_RX = 4'd4;
    localparam logic [3:0] KIND_RX_ERROR = 4'd5;
    localparam logic [3:0] KIND_TIMEOUT  = 4'd6;
    localparam logic [3:0] KIND_EXECUTE  = 4'd7;
    localparam logic [3:0] KIND_SENT     = 4'd8;
    localparam logic [3:0] KIND_BUSY     = 4'd9;
    localparam logic [3:0] KIND_BAD_ADDR = 4'd10;
    localparam logic [3:0] KIND_READ     = 4'd11;

    // timer requests
    localparam logic [2:0] TREQ_NONE    = 3'd0;
    localparam logic [2:0] TREQ_T35     = 3'd1;
    localparam logic [2:0] TREQ_RESPOND = 3'd2;
    localparam logic [2:0] TREQ_CONVERT = 3'd3;
    localparam logic [2:0] TREQ_DISABLE = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } mbf_in_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] out_byte;
        logic [7:0] frame_address;
        logic [7:0] pdu_length;
        logic       frame_valid;
        logic [2:0] timer_request;
        logic       last;
    } mbf_out_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] out_byte;
        logic [7:0] frame_address;
        logic [7:0] pdu_length;
        logic       frame_valid;
        logic [2:0] timer_request;
    } mbf_res_t;

    // all results of one item, plus where slot 0 takes its byte from
    typedef struct packed {
        mbf_res_t [2:0] slot;
        logic [1:0]     cnt;
        logic           use_rdata;
        logic           rd_tx;
    } mbf_item_t;

    // one byte of crc-16, reflected poly 0xa001
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ 16'hA001;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/mbf_chan_if.sv]
`default_nettype none

interface mbf_chan_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/modbus_rtu_master_framer.sv]
// path: an accepted item passes the input register, then the result slot, which shows its results
// throughput: one item per cycle while each item yields one result and the output is ready;
//   an item with more results holds the input while the output slot drains them, one per transfer
// reset: rst_n is asynchronous active low; receiver and sender go idle, crcs to 0xffff,
//   max slave address to 247; buffer contents stay undefined until written
`default_nettype none

module modbus_rtu_master_framer #(
    parameter int BUF_DEPTH = mbf_pkg::BUF_DEPTH_DEF
) (
    input logic              clk,
    input logic              rst_n,
    mbf_chan_if.sink         in_ch,
    mbf_chan_if.source       out_ch,
    mbf_chan_if.sink         cfg_ch
);

    localparam int AW = $clog2(BUF_DEPTH);

    // control between decode stage and result slot
    logic               load;
    logic               load_ok;
    mbf_pkg::mbf_item_t item;

    // buffer ports
    logic          rx_we, rx_re, tx_we, tx_re;
    logic [AW-1:0] rx_waddr, rx_raddr, tx_waddr, tx_raddr;
    logic [7:0]    rx_wdata, tx_wdata, rx_rdata, tx_rdata;

    mbf_pkg::mbf_in_t  in_data;
    mbf_pkg::mbf_out_t out_data;
    logic              in_ready;
    logic              out_valid;

    assign in_data      = in_ch.data;
    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_data;

    // the register write is always taken, ready is tied high
    assign cfg_ch.ready = 1'b1;

    // input register, state update, crc and result building
    mbf_core #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_data   (in_data),
        .in_ready  (in_ready),
        .cfg_valid (cfg_ch.valid),
        .cfg_data  (cfg_ch.data[7:0]),
        .load_ok   (load_ok),
        .load      (load),
        .item      (item),
        .rx_we     (rx_we),
        .rx_waddr  (rx_waddr),
        .rx_wdata  (rx_wdata),
        .rx_re     (rx_re),
        .rx_raddr  (rx_raddr),
        .tx_we     (tx_we),
        .tx_waddr  (tx_waddr),
        .tx_wdata  (tx_wdata),
        .tx_re     (tx_re),
        .tx_raddr  (tx_raddr)
    );

    // receive frame buffer, read back by index
    mbf_ram #(
        .DEPTH (BUF_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .re    (rx_re),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    // transmit frame buffer: address and pdu bytes, crc comes from the core
    mbf_ram #(
        .DEPTH (BUF_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    // result slot: hands out up to three results per item, one per transfer
    mbf_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .item      (item),
        .load_ok   (load_ok),
        .rx_rdata  (rx_rdata),
        .tx_rdata  (tx_rdata),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[hdl/mbf_ram.sv]
`default_nettype none

module mbf_ram #(
    parameter int DEPTH = mbf_pkg::BUF_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/mbf_core.sv]
`default_nettype none

module mbf_core #(
    parameter int BUF_DEPTH = mbf_pkg::BUF_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  mbf_pkg::mbf_in_t             in_data,
    output logic                         in_ready,
    input  logic                         cfg_valid,
    input  logic [7:0]                   cfg_data,
    input  logic                         load_ok,
    output logic                         load,
    output mbf_pkg::mbf_item_t           item,
    output logic                         rx_we,
    output logic [$clog2(BUF_DEPTH)-1:0] rx_waddr,
    output logic [7:0]                   rx_wdata,
    output logic                         rx_re,
    output logic [$clog2(BUF_DEPTH)-1:0] rx_raddr,
    output logic                         tx_we,
    output logic [$clog2(BUF_DEPTH)-1:0] tx_waddr,
    output logic [7:0]                   tx_wdata,
    output logic                         tx_re,
    output logic [$clog2(BUF_DEPTH)-1:0] tx_raddr
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int PW = (CW > 9) ? CW : 9;

    typedef enum logic [1:0] {RX_IDLE, RX_RCV, RX_ERR} rx_state_t;
    typedef enum logic [1:0] {TX_IDLE, TX_XMIT, TX_XFWR} tx_state_t;
    typedef enum logic [1:0] {TM_T35, TM_RESPOND, TM_CONVERT} timer_mode_t;

    logic              s1_valid_reg;
    mbf_pkg::mbf_in_t  s1_reg;
    logic [7:0]        max_addr_reg;

    rx_state_t   rx_state_reg, rx_state_next;
    tx_state_t   tx_state_reg, tx_state_next;
    timer_mode_t timer_mode_reg, timer_mode_next;
    logic [CW-1:0] rx_count_reg, rx_count_next;
    logic [15:0]   rx_crc_reg, rx_crc_next;
    logic [7:0]    rx_addr_reg, rx_addr_next;
    logic [CW-1:0] tx_length_reg, tx_length_next;
    logic [CW-1:0] tx_position_reg, tx_position_next;
    logic [15:0]   tx_crc_reg, tx_crc_next;
    logic [7:0]    tx_addr_reg, tx_addr_next;
    logic          is_bcast_reg, is_bcast_next;

    logic          fire;
    logic          rx_wr, rx_rd, tx_wr, tx_rd;
    logic [8:0]    rd_pos;
    logic          rd_pos_ok;
    logic [PW-1:0] len_full;
    logic [7:0]    pdu_len;
    logic          frame_ok;
    logic [CW:0]   tx_limit;
    logic [1:0]    n_c;
    mbf_pkg::mbf_item_t item_c;

    assign fire     = s1_valid_reg && load_ok;
    assign in_ready = !s1_valid_reg || load_ok;

    assign rd_pos    = {1'b0, s1_reg.read_index} + 9'd1;
    assign rd_pos_ok = (PW'(rd_pos) < PW'(rx_count_reg)) && (PW'(rd_pos) < PW'(BUF_DEPTH));
    assign len_full  = PW'(rx_count_reg) - PW'(3);
    assign pdu_len   = (len_full > PW'(255)) ? 8'hFF : len_full[7:0];
    assign frame_ok  = (PW'(rx_count_reg) >= PW'(mbf_pkg::PDU_SIZE_MIN)) && (rx_crc_reg == 16'h0000);
    assign tx_limit  = (CW + 1)'(tx_length_reg) + (CW + 1)'(2);

    always_comb
    begin
        rx_state_next    = rx_state_reg;
        tx_state_next    = tx_state_reg;
        timer_mode_next  = timer_mode_reg;
        rx_count_next    = rx_count_reg;
        rx_crc_next      = rx_crc_reg;
        rx_addr_next     = rx_addr_reg;
        tx_length_next   = tx_length_reg;
        tx_position_next = tx_position_reg;
        tx_crc_next      = tx_crc_reg;
        tx_addr_next     = tx_addr_reg;
        is_bcast_next    = is_bcast_reg;
        rx_wr    = 1'b0;
        rx_rd    = 1'b0;
        tx_wr    = 1'b0;
        tx_rd    = 1'b0;
        rx_waddr = '0;
        tx_waddr = '0;
        rx_raddr = AW'(rd_pos);
        tx_raddr = AW'(tx_position_reg);
        n_c      = 2'd0;
        item_c   = '0;
        item_c.cnt = 2'd1;
        item_c.slot[0].kind = mbf_pkg::KIND_ACK;

        case (s1_reg.cmd)
            mbf_pkg::CMD_RX_BYTE:
            begin
                if (rx_state_reg == RX_IDLE)
                begin
                    tx_state_next = TX_IDLE;
                    rx_wr         = 1'b1;
                    rx_waddr      = '0;
                    rx_addr_next  = s1_reg.data_byte;
                    rx_count_next = CW'(1);
                    rx_crc_next   = mbf_pkg::crc16_step(16'hFFFF, s1_reg.data_byte);
                    rx_state_next = RX_RCV;
                end
                else if (rx_state_reg == RX_RCV)
                begin
                    if (rx_count_reg < CW'(BUF_DEPTH))
                    begin
                        rx_wr         = 1'b1;
                        rx_waddr      = AW'(rx_count_reg);
                        rx_count_next = rx_count_reg + CW'(1);
                        rx_crc_next   = mbf_pkg::crc16_step(rx_crc_reg, s1_reg.data_byte);
                    end
                    else
                    begin
                        rx_state_next = RX_ERR;
                    end
                end
                timer_mode_next = TM_T35;
                item_c.slot[0].timer_request = mbf_pkg::TREQ_T35;
            end
            mbf_pkg::CMD_TX_READY:
            begin
                if (tx_state_reg == TX_XMIT)
                begin
                    if ((CW + 1)'(tx_position_reg) < tx_limit)
                    begin
                        item_c.slot[0].kind = mbf_pkg::KIND_TX_BYTE;
                        if (tx_position_reg < tx_length_reg)
                        begin
                            tx_rd            = 1'b1;
                            item_c.use_rdata = 1'b1;
                            item_c.rd_tx     = 1'b1;
                        end
                        else if (tx_position_reg == tx_length_reg)
                        begin
                            item_c.slot[0].out_byte = tx_crc_reg[7:0];
                        end
                        else
                        begin
                            item_c.slot[0].out_byte = tx_crc_reg[15:8];
                        end
                        tx_position_next = tx_position_reg + CW'(1);
                    end
                    else
                    begin
                        is_bcast_next = (tx_addr_reg == 8'h00);
                        tx_state_next = TX_XFWR;
                        item_c.slot[0].kind = mbf_pkg::KIND_TX_DONE;
                        if (tx_addr_reg == 8'h00)
                        begin
                            timer_mode_next = TM_CONVERT;
                            item_c.slot[0].timer_request = mbf_pkg::TREQ_CONVERT;
                        end
                        else
                        begin
                            timer_mode_next = TM_RESPOND;
                            item_c.slot[0].timer_request = mbf_pkg::TREQ_RESPOND;
                        end
                    end
                end
            end
            mbf_pkg::CMD_TIMER:
            begin
                item_c.slot[0].kind = mbf_pkg::KIND_ACK;
                if (rx_state_reg == RX_RCV)
                begin
                    item_c.slot[n_c].kind          = mbf_pkg::KIND_FRAME_RX;
                    item_c.slot[n_c].frame_valid   = frame_ok;
                    item_c.slot[n_c].frame_address = frame_ok ? rx_addr_reg : 8'h00;
                    item_c.slot[n_c].pdu_length    = frame_ok ? pdu_len : 8'h00;
                    n_c = n_c + 2'd1;
                end
                else if (rx_state_reg == RX_ERR)
                begin
                    item_c.slot[n_c].kind = mbf_pkg::KIND_RX_ERROR;
                    n_c = n_c + 2'd1;
                end
                rx_state_next = RX_IDLE;
                if (tx_state_reg == TX_XFWR && !is_bcast_reg)
                begin
                    item_c.slot[n_c].kind = mbf_pkg::KIND_TIMEOUT;
                    n_c = n_c + 2'd1;
                end
                tx_state_next = TX_IDLE;
                if (timer_mode_reg == TM_CONVERT)
                begin
                    item_c.slot[n_c].kind = mbf_pkg::KIND_EXECUTE;
                    n_c = n_c + 2'd1;
                end
                // the final result of a timer item turns the timer off
                if (n_c == 2'd0)
                begin
                    item_c.slot[0].timer_request = mbf_pkg::TREQ_DISABLE;
                    item_c.cnt = 2'd1;
                end
                else
                begin
                    item_c.slot[n_c - 2'd1].timer_request = mbf_pkg::TREQ_DISABLE;
                    item_c.cnt = n_c;
                end
            end
            mbf_pkg::CMD_ADDRESS:
            begin
                if (tx_state_reg != TX_XMIT)
                begin
                    tx_wr          = 1'b1;
                    tx_waddr       = '0;
                    tx_addr_next   = s1_reg.data_byte;
                    tx_length_next = CW'(1);
                    tx_crc_next    = mbf_pkg::crc16_step(16'hFFFF, s1_reg.data_byte);
                end
            end
            mbf_pkg::CMD_PDU_BYTE:
            begin
                if (tx_state_reg != TX_XMIT && tx_length_reg != '0
                    && tx_length_reg < CW'(BUF_DEPTH - 2))
                begin
                    tx_wr          = 1'b1;
                    tx_waddr       = AW'(tx_length_reg);
                    tx_length_next = tx_length_reg + CW'(1);
                    tx_crc_next    = mbf_pkg::crc16_step(tx_crc_reg, s1_reg.data_byte);
                end
            end
            mbf_pkg::CMD_SEND:
            begin
                if (tx_length_reg == '0 || tx_addr_reg > max_addr_reg)
                begin
                    item_c.slot[0].kind = mbf_pkg::KIND_BAD_ADDR;
                end
                else if (rx_state_reg != RX_IDLE)
                begin
                    item_c.slot[0].kind = mbf_pkg::KIND_BUSY;
                end
                else
                begin
                    // crc bytes are taken from tx_crc_reg while sending
                    tx_position_next = '0;
                    tx_state_next    = TX_XMIT;
                    item_c.slot[0].kind = mbf_pkg::KIND_SENT;
                end
            end
            mbf_pkg::CMD_READ:
            begin
                item_c.slot[0].kind = mbf_pkg::KIND_READ;
                if (rd_pos_ok)
                begin
                    rx_rd            = 1'b1;
                    item_c.use_rdata = 1'b1;
                end
            end
            default:
            begin
                item_c.slot[0].kind = mbf_pkg::KIND_ACK;
            end
        endcase
    end

    assign load     = fire;
    assign item     = item_c;
    assign rx_we    = fire && rx_wr;
    assign rx_re    = fire && rx_rd;
    assign tx_we    = fire && tx_wr;
    assign tx_re    = fire && tx_rd;
    assign rx_wdata = s1_reg.data_byte;
    assign tx_wdata = s1_reg.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_reg          <= '0;
            max_addr_reg    <= mbf_pkg::MAX_ADDR_RST;
            rx_state_reg    <= RX_IDLE;
            tx_state_reg    <= TX_IDLE;
            timer_mode_reg  <= TM_T35;
            rx_count_reg    <= '0;
            rx_crc_reg      <= 16'hFFFF;
            rx_addr_reg     <= '0;
            tx_length_reg   <= '0;
            tx_position_reg <= '0;
            tx_crc_reg      <= 16'hFFFF;
            tx_addr_reg     <= '0;
            is_bcast_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
                if (in_valid)
                begin
                    s1_reg <= in_data;
                end
            end
            if (cfg_valid)
            begin
                max_addr_reg <= cfg_data;
            end
            if (fire)
            begin
                rx_state_reg    <= rx_state_next;
                tx_state_reg    <= tx_state_next;
                timer_mode_reg  <= timer_mode_next;
                rx_count_reg    <= rx_count_next;
                rx_crc_reg      <= rx_crc_next;
                rx_addr_reg     <= rx_addr_next;
                tx_length_reg   <= tx_length_next;
                tx_position_reg <= tx_position_next;
                tx_crc_reg      <= tx_crc_next;
                tx_addr_reg     <= tx_addr_next;
                is_bcast_reg    <= is_bcast_next;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/mbf_out.sv]
`default_nettype none

`include "modbus_rtu_master_framer_assert.svh"

module mbf_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  mbf_pkg::mbf_item_t item,
    output logic               load_ok,
    input  logic [7:0]         rx_rdata,
    input  logic [7:0]         tx_rdata,
    output logic               out_valid,
    input  logic               out_ready,
    output mbf_pkg::mbf_out_t  out_data
);

    logic               occ_reg;
    logic [1:0]         sel_reg;
    mbf_pkg::mbf_item_t item_reg;
    mbf_pkg::mbf_res_t  res;
    logic               last_sel;
    logic               out_fire;

    assign last_sel  = (sel_reg == item_reg.cnt - 2'd1);
    assign out_fire  = occ_reg && out_ready;
    assign load_ok   = !occ_reg || (out_ready && last_sel);
    assign out_valid = occ_reg;
    assign res       = item_reg.slot[sel_reg];

    always_comb
    begin
        out_data.kind          = res.kind;
        out_data.frame_address = res.frame_address;
        out_data.pdu_length    = res.pdu_length;
        out_data.frame_valid   = res.frame_valid;
        out_data.timer_request = res.timer_request;
        out_data.last          = last_sel;
        if (item_reg.use_rdata)
        begin
            out_data.out_byte = item_reg.rd_tx ? tx_rdata : rx_rdata;
        end
        else
        begin
            out_data.out_byte = res.out_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            sel_reg <= 2'd0;
        end
        else if (load)
        begin
            occ_reg <= 1'b1;
            sel_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            if (last_sel)
            begin
                occ_reg <= 1'b0;
            end
            else
            begin
                sel_reg <= sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    `MBF_ASSERT_IMP(a_sel_in_range, clk, rst_n, occ_reg, sel_reg < item_reg.cnt, "result select past count")
    `MBF_ASSERT_IMP(a_cnt_nonzero, clk, rst_n, occ_reg, item_reg.cnt != 2'd0, "item holds no result")
    `MBF_ASSERT_IMP(a_rdata_single, clk, rst_n, occ_reg && item_reg.use_rdata, item_reg.cnt == 2'd1, "memory byte on multi-result item")
    `MBF_ASSERT_NXT(a_step, clk, rst_n, out_fire && !last_sel, occ_reg && sel_reg == $past(sel_reg) + 2'd1, "result select did not advance")
    `MBF_ASSERT_NXT(a_load, clk, rst_n, load, occ_reg && sel_reg == 2'd0, "load did not start at first result")

endmodule

`default_nettype wire

[tb/sv/mbf_tb_pkg.sv]
`default_nettype none

package mbf_tb_pkg;

    import mbf_pkg::*;

    localparam int DEPTH = BUF_DEPTH_DEF;

    // cmd code that the block does not decode
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef enum logic [1:0] {RCV_IDLE, RCV_FRAME, RCV_OVERRUN} rcv_state_e;
    typedef enum logic [1:0] {XMT_IDLE, XMT_SENDING, XMT_AWAIT_REPLY} xmt_state_e;
    typedef enum logic [1:0] {TMR_T35, TMR_RESPOND, TMR_CONVERT} tmr_mode_e;

    // modbus crc-16, one byte, lsb first
    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] val);
        logic [15:0] r;
        r = acc ^ 16'(val);
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    class framer_scoreboard;
        logic [7:0]  max_addr;
        rcv_state_e  rcv_state;
        xmt_state_e  xmt_state;
        tmr_mode_e   tmr_mode;
        logic [7:0]  rcv_buf [DEPTH];
        logic [8:0]  rcv_cnt;
        logic [15:0] rcv_crc;
        logic [7:0]  xmt_buf [DEPTH];
        logic [8:0]  xmt_len;
        logic [8:0]  xmt_pos;
        logic [15:0] xmt_crc;
        logic        to_broadcast;
        mbf_out_t    awaited_events [$];
        int          errors;

        function new();
            max_addr     = MAX_ADDR_RST;
            rcv_state    = RCV_IDLE;
            xmt_state    = XMT_IDLE;
            tmr_mode     = TMR_T35;
            rcv_cnt      = '0;
            rcv_crc      = 16'hFFFF;
            xmt_len      = '0;
            xmt_pos      = '0;
            xmt_crc      = 16'hFFFF;
            to_broadcast = 1'b0;
            errors       = 0;
        endfunction

        function void set_max_address(input logic [7:0] v);
            max_addr = v;
        endfunction

        function mbf_out_t make_event(input logic [3:0] k, input logic [7:0] ob = '0,
                                      input logic [7:0] fa = '0, input logic [7:0] pl = '0,
                                      input logic fv = 1'b0, input logic [2:0] tr = TREQ_NONE);
            mbf_out_t ev;
            ev               = '0;
            ev.kind          = k;
            ev.out_byte      = ob;
            ev.frame_address = fa;
            ev.pdu_length    = pl;
            ev.frame_valid   = fv;
            ev.timer_request = tr;
            return ev;
        endfunction

        // advance the framer state by one accepted command, queue its results
        function void note_command(input mbf_in_t c);
            mbf_out_t   evs [$];
            logic       ok;
            logic [7:0] len;
            logic [7:0] addr;
            logic [8:0] pos;
            logic [7:0] rd;
            case (c.cmd)
                CMD_RX_BYTE:
                begin
                    if (rcv_state == RCV_IDLE)
                    begin
                        xmt_state  = XMT_IDLE;
                        rcv_buf[0] = c.data_byte;
                        rcv_cnt    = 9'd1;
                        rcv_crc    = crc_update(16'hFFFF, c.data_byte);
                        rcv_state  = RCV_FRAME;
                    end
                    else if (rcv_state == RCV_FRAME)
                    begin
                        if (rcv_cnt < DEPTH)
                        begin
                            rcv_buf[rcv_cnt] = c.data_byte;
                            rcv_cnt          = rcv_cnt + 9'd1;
                            rcv_crc          = crc_update(rcv_crc, c.data_byte);
                        end
                        else
                        begin
                            rcv_state = RCV_OVERRUN;
                        end
                    end
                    tmr_mode = TMR_T35;
                    evs.push_back(make_event(KIND_ACK, '0, '0, '0, 1'b0, TREQ_T35));
                end
                CMD_TX_READY:
                begin
                    if (xmt_state == XMT_SENDING)
                    begin
                        if (xmt_pos < xmt_len + 9'd2 && xmt_pos < DEPTH)
                        begin
                            evs.push_back(make_event(KIND_TX_BYTE, xmt_buf[xmt_pos]));
                            xmt_pos = xmt_pos + 9'd1;
                        end
                        else
                        begin
                            to_broadcast = (xmt_buf[0] == 8'h00);
                            xmt_state    = XMT_AWAIT_REPLY;
                            tmr_mode     = to_broadcast ? TMR_CONVERT : TMR_RESPOND;
                            evs.push_back(make_event(KIND_TX_DONE, '0, '0, '0, 1'b0,
                                                     to_broadcast ? TREQ_CONVERT : TREQ_RESPOND));
                        end
                    end
                    else
                    begin
                        evs.push_back(make_event(KIND_ACK));
                    end
                end
                CMD_TIMER:
                begin
                    if (rcv_state == RCV_FRAME)
                    begin
                        ok   = (rcv_cnt >= PDU_SIZE_MIN) && (rcv_crc == 16'h0000);
                        len  = '0;
                        addr = '0;
                        if (ok)
                        begin
                            len  = (rcv_cnt > 9'd258) ? 8'hFF : 8'(rcv_cnt - 9'd3);
                            addr = rcv_buf[0];
                        end
                        evs.push_back(make_event(KIND_FRAME_RX, '0, addr, len, ok));
                    end
                    else if (rcv_state == RCV_OVERRUN)
                    begin
                        evs.push_back(make_event(KIND_RX_ERROR));
                    end
                    rcv_state = RCV_IDLE;
                    if (xmt_state == XMT_AWAIT_REPLY && !to_broadcast)
                    begin
                        evs.push_back(make_event(KIND_TIMEOUT));
                    end
                    xmt_state = XMT_IDLE;
                    if (tmr_mode == TMR_CONVERT)
                    begin
                        evs.push_back(make_event(KIND_EXECUTE));
                    end
                    // the final result of a timer item always shuts the timer off
                    if (evs.size() == 0)
                    begin
                        evs.push_back(make_event(KIND_ACK, '0, '0, '0, 1'b0, TREQ_DISABLE));
                    end
                    else
                    begin
                        evs[evs.size() - 1].timer_request = TREQ_DISABLE;
                    end
                end
                CMD_ADDRESS:
                begin
                    if (xmt_state != XMT_SENDING)
                    begin
                        xmt_buf[0] = c.data_byte;
                        xmt_len    = 9'd1;
                        xmt_crc    = crc_update(16'hFFFF, c.data_byte);
                    end
                    evs.push_back(make_event(KIND_ACK));
                end
                CMD_PDU_BYTE:
                begin
                    if (xmt_state != XMT_SENDING && xmt_len >= 9'd1 && xmt_len < DEPTH - 2)
                    begin
                        xmt_buf[xmt_len] = c.data_byte;
                        xmt_len          = xmt_len + 9'd1;
                        xmt_crc          = crc_update(xmt_crc, c.data_byte);
                    end
                    evs.push_back(make_event(KIND_ACK));
                end
                CMD_SEND:
                begin
                    if (xmt_len == 9'd0 || xmt_buf[0] > max_addr)
                    begin
                        evs.push_back(make_event(KIND_BAD_ADDR));
                    end
                    else if (rcv_state != RCV_IDLE)
                    begin
                        evs.push_back(make_event(KIND_BUSY));
                    end
                    else
                    begin
                        xmt_buf[xmt_len]         = xmt_crc[7:0];
                        xmt_buf[xmt_len + 9'd1]  = xmt_crc[15:8];
                        xmt_pos                  = '0;
                        xmt_state                = XMT_SENDING;
                        evs.push_back(make_event(KIND_SENT));
                    end
                end
                CMD_READ:
                begin
                    pos = 9'(c.read_index) + 9'd1;
                    rd  = (pos < rcv_cnt && pos < DEPTH) ? rcv_buf[pos] : 8'h00;
                    evs.push_back(make_event(KIND_READ, rd));
                end
                default:
                begin
                    evs.push_back(make_event(KIND_ACK));
                end
            endcase
            evs[evs.size() - 1].last = 1'b1;
            foreach (evs[i])
            begin
                awaited_events.push_back(evs[i]);
            end
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_event(input mbf_out_t got);
            mbf_out_t want;
            if (awaited_events.size() == 0)
            begin
                $error("kind: expected none, actual %0d", got.kind);
                errors++;
                return;
            end
            want = awaited_events.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("frame_address", want.frame_address, got.frame_address);
            compare_field("pdu_length", want.pdu_length, got.pdu_length);
            compare_field("frame_valid", want.frame_valid, got.frame_valid);
            compare_field("timer_request", want.timer_request, got.timer_request);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return awaited_events.size();
        endfunction

        function void report_leftover();
            if (awaited_events.size() != 0)
            begin
                $error("%0d results never arrived", awaited_events.size());
                errors += awaited_events.size();
            end
        endfunction
    endclass

endpackage

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mbf_pkg::*;
    import mbf_tb_pkg::*;

    // receiver flow patterns on the result channel
    typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_BLOCKS} flow_e;

    logic clk = 1'b0;
    logic rst_n;

    mbf_chan_if #(.T(mbf_in_t))    in_ch ();
    mbf_chan_if #(.T(mbf_out_t))   out_ch ();
    mbf_chan_if #(.T(logic [7:0])) cfg_ch ();

    modbus_rtu_master_framer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    framer_scoreboard sb = new();

    mbf_in_t     plan [$];         // commands queued for the next scenario
    logic [7:0]  cur_max;          // max slave address the block currently holds
    int unsigned burst_left = 0;   // commands left in the current sender burst
    int          random_items = 0; // items driven by the short random scenarios

    always #5ns clk = ~clk;

    // fixed ceiling on the whole run
    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    // every transfer is sampled at the clock edge, before the edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // results first: a command accepted at this edge has no result yet
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_event(out_ch.data);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.set_max_address(cfg_ch.data);
            end
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_command(in_ch.data);
            end
        end
    end

    // result receiver: switches between flow patterns at random
    initial
    begin
        flow_e       flow;
        int unsigned flow_left;
        int unsigned tick;
        flow_left = 0;
        tick      = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (flow_left == 0)
            begin
                flow      = flow_e'($urandom_range(0, 3));
                flow_left = $urandom_range(16, 160);
            end
            flow_left--;
            tick++;
            case (flow)
                FLOW_FREE:   out_ch.ready <= 1'b1;
                FLOW_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
                FLOW_SPARSE: out_ch.ready <= (tick % 4 == 0);
                default:     out_ch.ready <= (tick % 16 < 11);
            endcase
        end
    end

    // one command transfer; the sender runs in bursts with random gaps between them
    task automatic drive_command(input mbf_in_t c);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= c;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold off the sender until every predicted result has been seen
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        // leave some slack after the last result
        repeat (4) @(posedge clk);
    endtask

    // config transfers only happen with the block drained
    task automatic write_max_address(input logic [7:0] v);
        drain_results();
        cur_max = v;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void add(input logic [2:0] c, input logic [7:0] d = 8'h00);
        mbf_in_t item;
        item.cmd        = c;
        item.data_byte  = d;
        item.read_index = 8'($urandom_range(0, 255));
        plan.push_back(item);
    endfunction

    function automatic void add_read(input logic [7:0] idx);
        mbf_in_t item;
        item.cmd        = CMD_READ;
        item.data_byte  = 8'($urandom_range(0, 255));
        item.read_index = idx;
        plan.push_back(item);
    endfunction

    function automatic void add_tx_ready(input int n);
        repeat (n) add(CMD_TX_READY, 8'($urandom_range(0, 255)));
    endfunction

    // received frame of address plus pdu with its crc appended, optionally damaged
    function automatic void add_reply(input logic [7:0] addr, input int npdu,
                                      input logic damage);
        logic [7:0]  frame [$];
        logic [15:0] crc;
        int          at;
        crc = 16'hFFFF;
        frame.push_back(addr);
        repeat (npdu) frame.push_back(8'($urandom_range(0, 255)));
        foreach (frame[i])
        begin
            crc = crc_update(crc, frame[i]);
        end
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        if (damage)
        begin
            at = $urandom_range(0, frame.size() - 1);
            frame[at] = frame[at] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (frame[i])
        begin
            add(CMD_RX_BYTE, frame[i]);
        end
    endfunction

    // broadcast, in range, out of range or anything
    function automatic logic [7:0] pick_address();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return 8'($urandom_range(0, int'(cur_max)));
            4:       return (cur_max == 8'hFF) ? 8'hFF
                                               : 8'($urandom_range(int'(cur_max) + 1, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // request, its transmission, then a reply, a timeout or a convert delay
    function automatic void plan_transaction();
        logic [7:0] addr;
        int         npdu;
        int         nbytes;
        addr = pick_address();
        if ($urandom_range(0, 7) == 0)
        begin
            add(CMD_PDU_BYTE, 8'($urandom_range(0, 255)));
        end
        npdu = $urandom_range(0, 6);
        add(CMD_ADDRESS, addr);
        repeat (npdu) add(CMD_PDU_BYTE, 8'($urandom_range(0, 255)));
        add(CMD_SEND);
        nbytes = npdu + 3;
        case ($urandom_range(0, 5))
            0:
            begin
                // restart in the middle of the frame
                add_tx_ready($urandom_range(0, nbytes));
                add(CMD_SEND);
                add_tx_ready(nbytes + 1);
            end
            1:
            begin
                // cut short, a received byte or a timer event aborts the transmission
                add_tx_ready($urandom_range(0, nbytes));
            end
            2:
            begin
                // the same frame goes out twice
                add_tx_ready(nbytes + 1);
                add(CMD_SEND);
                add_tx_ready(nbytes + 1 + $urandom_range(0, 1));
            end
            default:
            begin
                add_tx_ready(nbytes + 1 + $urandom_range(0, 1));
            end
        endcase
        case ($urandom_range(0, 4))
            0:
            begin
                add(CMD_TIMER);
            end
            1, 2:
            begin
                add_reply(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : addr,
                          $urandom_range(0, 8), ($urandom_range(0, 4) == 0));
                if ($urandom_range(0, 2) == 0)
                begin
                    add(CMD_SEND);
                end
                add(CMD_TIMER);
            end
            3:
            begin
                repeat ($urandom_range(1, 3)) add(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
                add(CMD_TIMER);
                add(CMD_TIMER);
            end
            default:
            begin
                add(CMD_TIMER);
                add(CMD_TIMER);
            end
        endcase
        repeat ($urandom_range(0, 3)) add_read(8'($urandom_range(0, 10)));
    endfunction

    function automatic void plan_noise();
        repeat ($urandom_range(1, 6))
        begin
            add(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic play_plan(input logic counted);
        foreach (plan[i])
        begin
            drive_command(plan[i]);
        end
        if (counted)
        begin
            random_items += plan.size();
        end
        plan.delete();
    endtask

    task automatic random_phase(input int n);
        int goal;
        goal = random_items + n;
        while (random_items < goal)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    plan_noise();
                end
                2, 3:
                begin
                    add_reply(8'($urandom_range(0, 255)), $urandom_range(0, 8),
                              ($urandom_range(0, 3) == 0));
                    add(CMD_TIMER);
                    repeat ($urandom_range(1, 4)) add_read(8'($urandom_range(0, 12)));
                end
                default:
                begin
                    plan_transaction();
                end
            endcase
            play_plan(1'b1);
            // occasionally let everything drain before going on
            if ($urandom_range(0, 7) == 0)
            begin
                drain_results();
            end
        end
    endtask

    // buffer limits: full frame, overflow, and a request longer than the buffer
    task automatic buffer_limit_phase();
        logic [7:0] addr;
        // full buffer of 256 bytes that passes the crc check
        add_reply(8'($urandom_range(0, 255)), DEPTH - 3, 1'b0);
        add_read(8'd0);
        add_read(8'd253);
        add_read(8'd254);
        add_read(8'd255);
        add(CMD_TIMER);
        // frame too long for the buffer
        repeat (DEPTH + 2) add(CMD_RX_BYTE, 8'($urandom_range(0, 255)));
        add_read(8'($urandom_range(0, 254)));
        add(CMD_SEND);
        add(CMD_TIMER);
        // request whose pdu overruns the send buffer, tail bytes get dropped
        addr = 8'($urandom_range(1, int'(cur_max)));
        add(CMD_ADDRESS, addr);
        repeat (DEPTH) add(CMD_PDU_BYTE, 8'($urandom_range(0, 255)));
        add(CMD_SEND);
        add_tx_ready(DEPTH + 1);
        add(CMD_TIMER);
        play_plan(1'b0);
    endtask

    initial
    begin
        int guard;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        cur_max = MAX_ADDR_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_max_address(MAX_ADDR_RST);

        // directed corner cases
        add(CMD_UNUSED, 8'hA5);
        add(CMD_TIMER);                  // nothing to report
        add(CMD_TX_READY);               // not transmitting
        add(CMD_SEND);                   // no address yet
        add(CMD_PDU_BYTE, 8'hFF);        // pdu byte ahead of any address
        add_read(8'd0);                  // nothing received yet
        add(CMD_ADDRESS, 8'hFF);
        add(CMD_SEND);                   // address above the limit
        add(CMD_ADDRESS, 8'h00);
        add(CMD_PDU_BYTE, 8'h00);
        add(CMD_PDU_BYTE, 8'hFF);
        add(CMD_SEND);                   // broadcast
        add(CMD_ADDRESS, 8'h11);         // ignored while transmitting
        add_tx_ready(6);
        add(CMD_TIMER);                  // execute
        add(CMD_TIMER);                  // execute again, mode kept
        add_reply(8'hFF, 1, 1'b0);
        add(CMD_TIMER);                  // shortest valid frame
        add_read(8'd0);
        add_read(8'd3);                  // past the frame
        play_plan(1'b0);

        write_max_address(8'hFF);
        random_phase(120);

        write_max_address(8'h00);
        random_phase(110);

        write_max_address(8'($urandom_range(1, 254)));
        buffer_limit_phase();

        write_max_address(8'($urandom_range(0, 255)));
        random_phase(120);

        // wait for the tail of the results, bounded
        in_ch.valid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (sb.pending() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        sb.report_leftover();
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

[modbus_rtu_master_framer.f]
+incdir+hdl
hdl/mbf_pkg.sv
hdl/mbf_chan_if.sv
hdl/mbf_ram.sv
hdl/mbf_core.sv
hdl/mbf_out.sv
hdl/modbus_rtu_master_framer.sv
tb/sv/mbf_tb_pkg.sv
tb/sv/testbench.sv
